// File: sv/multi_level_page_table_walker_defines.svh
// Assertion macros for the page table walker.
// Depends on clk and arst_n being visible in the module that expands them.
`ifndef MULTI_LEVEL_PAGE_TABLE_WALKER_DEFINES_SVH
`define MULTI_LEVEL_PAGE_TABLE_WALKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MLPTW_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MLPTW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/mlptw_pkg.sv
// Shared constants and register codes of the page table walker.
// No dependencies; used by the walker top level.
`timescale 1ns / 1ps

package mlptw_pkg;

	// Frame count must be a power of two: frame numbers wrap by dropping high bits.
	localparam int NUM_FRAMES = 64;
	localparam int LEVELS     = 5;

	localparam int ENTRY_W    = 64;
	localparam int IDX_W      = 9;
	localparam int ENTRIES    = 1 << IDX_W;
	localparam int PAGE_SHIFT = 12;
	localparam int VPN_W      = 45;
	localparam int PPN_W      = 52;
	localparam int REG_W      = 6;
	localparam int CFG_IDX_W  = 1;

	localparam int FRAME_W    = $clog2(NUM_FRAMES);
	localparam int CNT_W      = $clog2(NUM_FRAMES + 1);
	localparam int LVL_W      = $clog2(LEVELS);
	localparam int ADDR_W     = FRAME_W + IDX_W;
	localparam int MEM_DEPTH  = NUM_FRAMES * ENTRIES;

	localparam logic [PPN_W-1:0] UNMAPPED_PAGE = '1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ROOT_FRAME  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ALLOC_START = 1'b1;

	// Request actions.
	localparam logic ACT_UPDATE = 1'b0;
	localparam logic ACT_QUERY  = 1'b1;

endpackage

// File: sv/mlptw_ram.sv
// Generic single-clock RAM: one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module mlptw_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port, registered.
	always_ff @(posedge clk) begin
		if (re) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: sv/multi_level_page_table_walker.sv
// Each level is walked in a read state and a check state; an update adds a write state for
// each entry it writes. The first nonzero write into a frame still flagged zero adds a
// clearing pass over that frame first (up to five per walk).
// One request at a time, taken at the edge that ends the previous result cycle; the
// receiver cannot stall results.
// Reset: no clearing pass; per-frame zero flags make every frame read as zero at once.
`timescale 1ns / 1ps
`include "multi_level_page_table_walker_defines.svh"

module multi_level_page_table_walker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	output logic                                done,
	input  logic                                action,
	input  logic [mlptw_pkg::VPN_W-1:0]         virt_page,
	input  logic [mlptw_pkg::PPN_W-1:0]         phys_page,
	output logic                                mapped,
	output logic [mlptw_pkg::PPN_W-1:0]         found_page,
	output logic                                status,
	input  logic                                cfg_we,
	input  logic [mlptw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mlptw_pkg::REG_W-1:0]         cfg_wdata
);

	import mlptw_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_WRITE,
		ST_CLEAR
	} state_t;

	state_t              state_q;
	logic                action_q;
	logic [VPN_W-1:0]    vpn_q;
	logic [PPN_W-1:0]    ppn_q;
	logic [FRAME_W-1:0]  frame_q;
	logic [FRAME_W-1:0]  frame_nx_q;
	logic [LVL_W-1:0]    lvl_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [ENTRY_W-1:0]  wr_data_q;
	logic                cont_q;
	logic [IDX_W-1:0]    clr_cnt_q;
	logic [NUM_FRAMES-1:0] zero_q;
	logic                rd_zero_q;
	logic [CNT_W-1:0]    next_free_q;
	logic [REG_W-1:0]    root_frame_q;
	logic                done_q;
	logic                mapped_q;
	logic [PPN_W-1:0]    found_q;
	logic                status_q;

	logic [VPN_W-1:0]    vpn_shifted;
	logic [IDX_W-1:0]    slot_idx;
	logic [ENTRY_W-1:0]  rd_data;
	logic [ENTRY_W-1:0]  entry;
	logic                entry_valid;
	logic [FRAME_W-1:0]  entry_frame;
	logic                last_level;
	logic                is_remove;
	logic [FRAME_W-1:0]  fresh;
	logic                mem_we;
	logic                mem_re;
	logic [ADDR_W-1:0]   mem_wr_addr;
	logic [ENTRY_W-1:0]  mem_wr_data;

	// Index of the current level: nine bits of the page number, top group first.
	assign vpn_shifted = vpn_q >> (IDX_W * (LEVELS - 1 - int'(lvl_q)));
	assign slot_idx    = vpn_shifted[IDX_W-1:0];

	// Entry seen by the walk; a frame still flagged zero reads as all zero.
	assign entry       = rd_zero_q ? '0 : rd_data;
	assign entry_valid = entry[0];
	assign entry_frame = entry[PAGE_SHIFT +: FRAME_W];
	assign last_level  = (lvl_q == LVL_W'(LEVELS - 1));
	assign is_remove   = (ppn_q == UNMAPPED_PAGE);
	assign fresh       = next_free_q[FRAME_W-1:0];

	// Memory port control: reads while walking, writes for updates and frame clears.
	assign mem_re      = (state_q == ST_READ);
	assign mem_we      = (state_q == ST_CLEAR) || ((state_q == ST_WRITE) && !zero_q[frame_q]);
	assign mem_wr_addr = (state_q == ST_CLEAR) ? {frame_q, clr_cnt_q} : addr_q;
	assign mem_wr_data = (state_q == ST_CLEAR) ? '0 : wr_data_q;

	mlptw_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MEM_DEPTH)
	) u_frame_ram (
		.clk     (clk),
		.we      (mem_we),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.re      (mem_re),
		.rd_addr ({frame_q, slot_idx}),
		.rd_data (rd_data)
	);

	// Walk sequencer, allocator, configuration registers and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			action_q     <= ACT_UPDATE;
			vpn_q        <= '0;
			ppn_q        <= '0;
			frame_q      <= '0;
			frame_nx_q   <= '0;
			lvl_q        <= '0;
			addr_q       <= '0;
			wr_data_q    <= '0;
			cont_q       <= 1'b0;
			clr_cnt_q    <= '0;
			zero_q       <= '1;
			rd_zero_q    <= 1'b0;
			next_free_q  <= CNT_W'(1);
			root_frame_q <= '0;
			done_q       <= 1'b0;
			mapped_q     <= 1'b0;
			found_q      <= '0;
			status_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					// The result strobe is raised only on the way into idle.
					done_q <= 1'b0;
					if (start) begin
						action_q <= action;
						vpn_q    <= virt_page;
						ppn_q    <= phys_page;
						frame_q  <= FRAME_W'(root_frame_q);
						lvl_q    <= '0;
						state_q  <= ST_READ;
					end
				end
				ST_READ: begin
					addr_q    <= {frame_q, slot_idx};
					rd_zero_q <= zero_q[frame_q];
					state_q   <= ST_CHECK;
				end
				ST_CHECK: begin
					if (action_q == ACT_QUERY) begin
						// Lookup: stop at an invalid entry, return the leaf page.
						if (!entry_valid) begin
							done_q   <= 1'b1;
							mapped_q <= 1'b0;
							found_q  <= UNMAPPED_PAGE;
							status_q <= 1'b0;
							state_q  <= ST_IDLE;
						end else if (last_level) begin
							done_q   <= 1'b1;
							mapped_q <= 1'b1;
							found_q  <= entry[PAGE_SHIFT +: PPN_W];
							status_q <= 1'b0;
							state_q  <= ST_IDLE;
						end else begin
							frame_q <= entry_frame;
							lvl_q   <= lvl_q + LVL_W'(1);
							state_q <= ST_READ;
						end
					end else if (is_remove) begin
						// Removal: zero the leaf or the first invalid inner entry.
						if (entry_valid && !last_level) begin
							frame_q <= entry_frame;
							lvl_q   <= lvl_q + LVL_W'(1);
							state_q <= ST_READ;
						end else begin
							wr_data_q <= '0;
							cont_q    <= 1'b0;
							state_q   <= ST_WRITE;
						end
					end else if (last_level) begin
						// Map: write the leaf entry.
						wr_data_q <= {ppn_q, {(PAGE_SHIFT-1){1'b0}}, 1'b1};
						cont_q    <= 1'b0;
						state_q   <= ST_WRITE;
					end else if (entry_valid) begin
						frame_q <= entry_frame;
						lvl_q   <= lvl_q + LVL_W'(1);
						state_q <= ST_READ;
					end else if (next_free_q < CNT_W'(NUM_FRAMES)) begin
						// Allocate the next frame; it reads as zero until first written.
						zero_q[fresh] <= 1'b1;
						next_free_q   <= next_free_q + CNT_W'(1);
						wr_data_q     <= {{(ENTRY_W-PAGE_SHIFT-FRAME_W){1'b0}}, fresh,
							{(PAGE_SHIFT-1){1'b0}}, 1'b1};
						frame_nx_q    <= fresh;
						cont_q        <= 1'b1;
						state_q       <= ST_WRITE;
					end else begin
						done_q   <= 1'b1;
						mapped_q <= 1'b0;
						found_q  <= '0;
						status_q <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				ST_WRITE: begin
					if (zero_q[frame_q] && (wr_data_q != '0)) begin
						// The target frame must be cleared before its first entry lands.
						clr_cnt_q <= '0;
						state_q   <= ST_CLEAR;
					end else if (cont_q) begin
						frame_q <= frame_nx_q;
						lvl_q   <= lvl_q + LVL_W'(1);
						state_q <= ST_READ;
					end else begin
						done_q   <= 1'b1;
						mapped_q <= 1'b0;
						found_q  <= '0;
						status_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + IDX_W'(1);
					if (clr_cnt_q == '1) begin
						zero_q[frame_q] <= 1'b0;
						state_q         <= ST_WRITE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// Register writes must arrive only while the walker is idle; the block does not enforce it.
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ROOT_FRAME:  root_frame_q <= cfg_wdata;
					REG_ALLOC_START: next_free_q  <= CNT_W'(cfg_wdata);
					default: begin
					end
				endcase
			end
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign mapped     = mapped_q;
	assign found_page = found_q;
	assign status     = status_q;

	// Result strobe lasts one cycle, and an accepted request makes the walker busy.
	`MLPTW_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe held longer than one cycle")
	`MLPTW_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not start a walk")
	// The memory is written only during a walk, and only zero frames are swept.
	`MLPTW_ASSERT_NOW(a_no_idle_write, mem_we, state_q != ST_IDLE, "frame memory written while idle")
	`MLPTW_ASSERT_NOW(a_clear_zero, state_q == ST_CLEAR, zero_q[frame_q], "clearing a live frame")
	`MLPTW_ASSERT_NOW(a_status_update, done && status, !mapped && found_page == '0,
		"out-of-frames result carries query data")

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the five-level page table walker.
// Depends on mlptw_pkg and multi_level_page_table_walker; predicts every result with its own
// model of the frame memory, allocator and registers.
`timescale 1ns / 1ps

module testbench;
	import mlptw_pkg::*;

	// The largest walk clears up to five frames (root plus four new ones), so the quiet limit
	// lies far beyond any correct gap.
	localparam int QUIET_LIMIT   = 20000;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES   = 20;
	localparam int WALKS_PER_SET = 120;

	typedef enum logic [1:0] {OP_WALK, OP_CONFIG, OP_DRAIN} op_kind_t;

	typedef struct {
		op_kind_t               kind;
		logic                   act;
		logic [VPN_W-1:0]       vpn;
		logic [PPN_W-1:0]       ppn;
		logic [CFG_IDX_W-1:0]   idx;
		logic [REG_W-1:0]       data;
	} walk_op_t;

	typedef struct {
		logic               mapped;
		logic [PPN_W-1:0]   found_page;
		logic               status;
	} walk_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic                   busy;
	logic                   done;
	logic                   action = ACT_UPDATE;
	logic [VPN_W-1:0]       virt_page = '0;
	logic [PPN_W-1:0]       phys_page = '0;
	logic                   mapped;
	logic [PPN_W-1:0]       found_page;
	logic                   status;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [REG_W-1:0]       cfg_wdata = '0;

	// Predicted machine state.
	bit   [ENTRY_W-1:0]     page_mem [MEM_DEPTH];
	logic [FRAME_W-1:0]     root_sel = '0;
	int                     alloc_next = 1;

	walk_op_t               walk_ops[$];
	walk_result_t           pending_walks[$];
	logic [VPN_W-1:0]       known_pages[$];
	logic [IDX_W-1:0]       group_pool [LEVELS][4];
	int                     in_flight = 0;
	int                     accepted_walks = 0;
	int                     settle_cnt = 0;
	int                     quiet_cycles = 0;
	int                     fail_cnt = 0;

	multi_level_page_table_walker dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// Address of the entry that a walk reads at one level of one frame.
	function automatic int entry_addr(logic [FRAME_W-1:0] frame, logic [VPN_W-1:0] vpn,
			int lvl);
		return int'(frame) * ENTRIES + int'(vpn[(LEVELS - 1 - lvl) * IDX_W +: IDX_W]);
	endfunction

	// Walks the predicted tables for one request and applies its side effects.
	function automatic walk_result_t walk_table(logic act, logic [VPN_W-1:0] vpn,
			logic [PPN_W-1:0] ppn);
		walk_result_t           res;
		logic [FRAME_W-1:0]     frame;
		int                     addr;
		int                     lvl;
		int                     e;
		res = '{mapped: 1'b0, found_page: '0, status: 1'b0};
		frame = root_sel;
		if (act == ACT_QUERY) begin
			for (lvl = 0; lvl < LEVELS - 1; lvl++) begin
				addr = entry_addr(frame, vpn, lvl);
				if (!page_mem[addr][0]) begin
					res.found_page = UNMAPPED_PAGE;
					return res;
				end
				frame = page_mem[addr][PAGE_SHIFT +: FRAME_W];
			end
			addr = entry_addr(frame, vpn, LEVELS - 1);
			if (page_mem[addr][0]) begin
				res.mapped = 1'b1;
				res.found_page = page_mem[addr][PAGE_SHIFT +: PPN_W];
			end else begin
				res.found_page = UNMAPPED_PAGE;
			end
			return res;
		end
		// Removal zeroes the leaf, or the first invalid inner entry on the way down.
		if (ppn == UNMAPPED_PAGE) begin
			for (lvl = 0; lvl < LEVELS - 1; lvl++) begin
				addr = entry_addr(frame, vpn, lvl);
				if (!page_mem[addr][0]) begin
					page_mem[addr] = '0;
					return res;
				end
				frame = page_mem[addr][PAGE_SHIFT +: FRAME_W];
			end
			page_mem[entry_addr(frame, vpn, LEVELS - 1)] = '0;
			return res;
		end
		// Mapping allocates missing inner tables and stops when frames run out.
		for (lvl = 0; lvl < LEVELS - 1; lvl++) begin
			addr = entry_addr(frame, vpn, lvl);
			if (!page_mem[addr][0]) begin
				if (alloc_next >= NUM_FRAMES) begin
					res.status = 1'b1;
					return res;
				end
				for (e = 0; e < ENTRIES; e++)
					page_mem[alloc_next * ENTRIES + e] = '0;
				page_mem[addr] = (ENTRY_W'(alloc_next) << PAGE_SHIFT) | ENTRY_W'(1);
				alloc_next++;
			end
			frame = page_mem[addr][PAGE_SHIFT +: FRAME_W];
		end
		page_mem[entry_addr(frame, vpn, LEVELS - 1)] = (ENTRY_W'(ppn) << PAGE_SHIFT) | ENTRY_W'(1);
		return res;
	endfunction

	function automatic void write_register(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] data);
		if (idx == REG_ROOT_FRAME) begin
			root_sel = data;
		end else if (idx == REG_ALLOC_START) begin
			alloc_next = int'(data);
		end
	endfunction

	function automatic logic [PPN_W-1:0] rand_page();
		return PPN_W'({$urandom, $urandom});
	endfunction

	// Page numbers drawn mostly from a few index groups per level so that walks share tables.
	function automatic logic [VPN_W-1:0] shared_page();
		logic [VPN_W-1:0]   vpn;
		int                 lvl;
		vpn = '0;
		for (lvl = 0; lvl < LEVELS; lvl++) begin
			if ($urandom_range(0, 7) == 0 || (lvl == LEVELS - 1 && $urandom_range(0, 1) == 0))
				vpn[(LEVELS - 1 - lvl) * IDX_W +: IDX_W] = IDX_W'($urandom_range(0, ENTRIES - 1));
			else
				vpn[(LEVELS - 1 - lvl) * IDX_W +: IDX_W] = group_pool[lvl][$urandom_range(0, 3)];
		end
		return vpn;
	endfunction

	function automatic logic [VPN_W-1:0] some_page();
		if (known_pages.size() != 0 && $urandom_range(0, 3) != 0)
			return known_pages[$urandom_range(0, known_pages.size() - 1)];
		return shared_page();
	endfunction

	task automatic add_walk(logic act, logic [VPN_W-1:0] vpn, logic [PPN_W-1:0] ppn);
		walk_ops.push_back('{kind: OP_WALK, act: act, vpn: vpn, ppn: ppn, idx: '0, data: '0});
	endtask

	task automatic add_config(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] data);
		walk_ops.push_back('{kind: OP_CONFIG, act: ACT_UPDATE, vpn: '0, ppn: '0, idx: idx,
			data: data});
	endtask

	task automatic add_drain();
		walk_ops.push_back('{kind: OP_DRAIN, act: ACT_UPDATE, vpn: '0, ppn: '0, idx: '0,
			data: '0});
	endtask

	// One phase: set root and allocation start, then random requests, mostly walks over shared tables.
	task automatic add_random_set(logic [REG_W-1:0] root, logic [REG_W-1:0] base);
		int                 n;
		int                 pick;
		logic [VPN_W-1:0]   vpn;
		add_config(REG_ROOT_FRAME, root);
		add_config(REG_ALLOC_START, base);
		for (n = 0; n < WALKS_PER_SET; n++) begin
			pick = $urandom_range(0, 99);
			if (n == WALKS_PER_SET / 2)
				add_drain();
			if (pick < 35) begin
				vpn = shared_page();
				known_pages.push_back(vpn);
				add_walk(ACT_UPDATE, vpn, ($urandom_range(0, 9) == 0) ? UNMAPPED_PAGE - 1'b1
					: rand_page());
			end else if (pick < 60) begin
				add_walk(ACT_QUERY, some_page(), rand_page());
			end else if (pick < 72) begin
				add_walk(ACT_UPDATE, some_page(), UNMAPPED_PAGE);
			end else if (pick < 85) begin
				add_walk(ACT_QUERY, shared_page(), rand_page());
			end else begin
				add_walk(logic'($urandom_range(0, 1)), VPN_W'({$urandom, $urandom}),
					($urandom_range(0, 3) == 0) ? UNMAPPED_PAGE : rand_page());
			end
		end
	endtask

	// Request driver: launches queued requests and register writes.
	always @(posedge clk) begin
		logic       start_n;
		logic       we_n;
		logic       idle_now;
		walk_op_t   op;
		if (arst_n) begin
			start_n = start;
			we_n = 1'b0;
			if (done && in_flight > 0)
				in_flight--;
			if (start && !busy) begin
				pending_walks.push_back(walk_table(action, virt_page, phys_page));
				in_flight++;
				accepted_walks++;
				start_n = 1'b0;
			end
			if (!start_n && walk_ops.size() != 0) begin
				if (walk_ops[0].kind == OP_WALK) begin
					idle_now = ($urandom_range(0, 99) < 37)
						&& !(accepted_walks >= 300 && accepted_walks < 420);
					if (!idle_now) begin
						op = walk_ops.pop_front();
						start_n = 1'b1;
						action <= op.act;
						virt_page <= op.vpn;
						phys_page <= op.ppn;
					end
				end else if (in_flight == 0) begin
					// Registers change only once every result is back and the block settled.
					settle_cnt++;
					if (settle_cnt >= SETTLE_CYCLES) begin
						settle_cnt = 0;
						op = walk_ops.pop_front();
						if (op.kind == OP_CONFIG) begin
							we_n = 1'b1;
							cfg_index <= op.idx;
							cfg_wdata <= op.data;
							write_register(op.idx, op.data);
						end
					end
				end
			end
			start <= start_n;
			cfg_we <= we_n;
		end
	end

	// Result monitor: each strobed result is checked against the oldest prediction.
	always @(posedge clk) begin
		walk_result_t   want;
		if (arst_n && done) begin
			if (pending_walks.size() == 0) begin
				$display("%0t: result with no request outstanding: mapped=%0b page=%h status=%0b",
					$time, mapped, found_page, status);
				fail_cnt++;
			end else begin
				want = pending_walks.pop_front();
				if (mapped !== want.mapped) begin
					$display("%0t: mapped expected %0b actual %0b", $time, want.mapped, mapped);
					fail_cnt++;
				end
				if (found_page !== want.found_page) begin
					$display("%0t: found_page expected %h actual %h", $time, want.found_page,
						found_page);
					fail_cnt++;
				end
				if (status !== want.status) begin
					$display("%0t: status expected %0b actual %0b", $time, want.status, status);
					fail_cnt++;
				end
			end
		end
	end

	// Watchdog on cycles in which nothing moves.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("multi_level_page_table_walker: mismatch");
			$finish;
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		int lvl;
		int g;
		for (lvl = 0; lvl < LEVELS; lvl++) begin
			group_pool[lvl][0] = '0;
			group_pool[lvl][1] = '1;
			for (g = 2; g < 4; g++)
				group_pool[lvl][g] = IDX_W'($urandom_range(0, ENTRIES - 1));
		end

		// Empty table, extremes of both pages, removal of a leaf.
		add_walk(ACT_QUERY, '0, '0);
		add_walk(ACT_UPDATE, '0, '0);
		add_walk(ACT_QUERY, '0, '1);
		add_walk(ACT_UPDATE, '1, UNMAPPED_PAGE - 1'b1);
		add_walk(ACT_QUERY, '1, UNMAPPED_PAGE);
		add_walk(ACT_UPDATE, 45'h0AAA_AAAA_AAAA, 52'hA_AAAA_AAAA_AAAA);
		add_walk(ACT_UPDATE, 45'h1555_5555_5555, 52'h5_5555_5555_5555);
		add_walk(ACT_QUERY, 45'h0AAA_AAAA_AAAA, '0);
		add_walk(ACT_UPDATE, '0, UNMAPPED_PAGE);
		add_walk(ACT_QUERY, '0, '0);
		add_walk(ACT_QUERY, 45'h1, '0);
		// Removal that stops at a missing inner table, and one at a missing top entry.
		add_walk(ACT_UPDATE, ~(VPN_W'(ENTRIES - 1) << (2 * IDX_W)), UNMAPPED_PAGE);
		add_walk(ACT_UPDATE, VPN_W'(9'h0F0) << (4 * IDX_W), UNMAPPED_PAGE);
		add_walk(ACT_QUERY, '1, '0);

		// Two free frames under the top root: the walk clears its own root and runs dry.
		add_config(REG_ROOT_FRAME, 6'd63);
		add_config(REG_ALLOC_START, 6'd62);
		add_walk(ACT_UPDATE, 45'h0123_4567_89AB, rand_page());
		add_walk(ACT_QUERY, 45'h0123_4567_89AB, '0);
		add_walk(ACT_UPDATE, '0, 52'h5);
		add_config(REG_ALLOC_START, 6'd63);
		add_walk(ACT_UPDATE, 45'h1FFF_0000_0001, rand_page());
		add_walk(ACT_QUERY, 45'h1FFF_0000_0001, '0);

		add_random_set(6'd0, 6'd1);
		add_random_set(6'd63, 6'd0);
		add_random_set(6'd21, 6'd40);
		add_random_set(6'd0, 6'd63);
		add_random_set(6'd40, 6'd5);
		add_random_set(6'd7, 6'd7);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Checked between edges so that the driver's updates of this edge are all visible.
		while (walk_ops.size() != 0 || start || in_flight != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_cnt == 0 && pending_walks.size() == 0) begin
			$display("multi_level_page_table_walker: match");
		end else begin
			$display("multi_level_page_table_walker: mismatch");
		end
		$finish;
	end

endmodule
